// ===== hdl/bkm_log2_exp2_top_macros.svh =====
// assertion helpers for the bkm log2 / exp2 unit
`ifndef BKM_LOG2_EXP2_TOP_MACROS_SVH
`define BKM_LOG2_EXP2_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BKM_ASSERT_IMP(name, clock, resetn, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error(msg);
`define BKM_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BKM_ASSERT_IMP(name, clock, resetn, ante, cons, msg)
`define BKM_ASSERT_NEXT(name, clock, resetn, ante, cons, msg)
`endif

`endif

// ===== hdl/bkm_pkg.sv =====
`timescale 1ns / 1ps

package bkm_pkg;

  localparam int FRAC_BITS   = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int INT_W       = 64 - FRAC_BITS;
  localparam int ROM_N       = 64;

  localparam logic [5:0]  ITER_RESET = 6'd31;
  localparam logic [63:0] ONE_Q63    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNDEF  = 2'd1,
    ST_NEGINF = 2'd2,
    ST_OVF    = 2'd3
  } bkm_status_t;

  typedef enum logic [1:0] {
    K_LOG,
    K_EXP,
    K_UNDEF,
    K_NEGINF
  } bkm_kind_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_NORM,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_FIN
  } core_state_t;

  // classified job handed from the front end to the iteration core
  typedef struct packed {
    bkm_kind_t               kind;
    logic [63:0]             val;   // normalized mantissa or fraction of the exp argument
    logic [5:0]              p;     // log2 integer part before offset
    logic signed [INT_W-1:0] fl;    // floor of the exp operand
  } bkm_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bkm_qstat_t;

  typedef logic [ROM_N-1:0][63:0] rom_t;

  // integer squaring log2 of a Q1.63 value, evaluated at elaboration only
  function automatic logic [63:0] sq_log(input logic [63:0] z0);
    logic [63:0]  z;
    logic [63:0]  m;
    logic [127:0] sq;
    int           j;
    z = z0;
    m = '0;
    for (j = 1; j <= 63; j++) begin
      sq = {64'd0, z} * {64'd0, z};
      if (sq[127]) begin
        z = sq[127:64];
        m[63-j] = 1'b1;
      end else begin
        z = sq[126:63];
      end
    end
    return m;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    int   k;
    for (k = 0; k < ROM_N; k++) begin
      if (k == 0) r[k] = ONE_Q63;
      else        r[k] = sq_log(ONE_Q63 + (64'd1 << (63 - k)));
    end
    return r;
  endfunction

  // log2(1 + 2^-k) in Q0.63
  localparam rom_t LOG_ROM = build_rom();

endpackage

// ===== hdl/bkm_log2_exp2_top.sv =====
`timescale 1ns / 1ps
// fixed-point log2 / exp2 unit using bkm shift-add iterations
// input channel: in_valid / in_ready with in_mode (0 log2, 1 exp2) and a signed
//   in_operand with FRAC_BITS fraction bits; a transfer happens when both are high
// output channel: out_valid / out_ready with out_result and out_status
//   (0 ok, 1 undefined, 2 negative infinity, 3 saturated)
// cfg_we / cfg_wdata set the iteration count (reset 31); write it only while idle
// the front end classifies each item and, for log2, normalizes the mantissa;
//   the core runs shift-add steps up to min(count, TABLE_DEPTH), from step 0
//   for exp2 and from step 1 for log2, one shift-add step per cycle through two
//   adders, one compare and the log table
// the core's iteration loop sets the item rate; the front end takes and
//   normalizes the next item meanwhile
// a queue of QUEUE_DEPTH jobs separates the front end from the core
// reset clears the front end, queue, core and output valid and restores the
//   iteration count; the table is constant
// while the receiver stalls the result holds, the core parks one finished job,
//   the queue fills and in_ready then drops
`include "bkm_log2_exp2_top_macros.svh"

module bkm_log2_exp2_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [63:0] in_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_result,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata
);

  logic [5:0]          iter_count_r;
  logic                q_push, q_pop;
  bkm_pkg::bkm_job_t   push_job, pop_job;
  bkm_pkg::bkm_qstat_t q_stat;
  logic [63:0]         result_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_count_r <= bkm_pkg::ITER_RESET;
    end else if (cfg_we) begin
      iter_count_r <= cfg_wdata;
    end
  end

  bkm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_operand (in_operand),
    .push       (q_push),
    .push_job   (push_job),
    .qstat      (q_stat)
  );

  bkm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .qstat    (q_stat)
  );

  bkm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .iter_count (iter_count_r),
    .job_valid  (!q_stat.empty),
    .job        (pop_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result_u),
    .out_status (out_status)
  );

  assign out_result = $signed(result_u);

  `BKM_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty, "pop from an empty queue")
  `BKM_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready, "two items back to back")
  `BKM_ASSERT_IMP(a_undef_zero, clk, rst_n, out_valid && (out_status == bkm_pkg::ST_UNDEF), result_u == 64'd0, "undefined result not zero")

endmodule

// ===== hdl/bkm_front.sv =====
`timescale 1ns / 1ps

module bkm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic signed [63:0]  in_operand,
  output logic                push,
  output bkm_pkg::bkm_job_t   push_job,
  input  bkm_pkg::bkm_qstat_t qstat
);

  bkm_pkg::front_state_t state_r, state_nxt;
  bkm_pkg::bkm_job_t     job_r, job_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bkm_pkg::FS_IDLE: begin
        if (in_valid) begin
          if (!in_mode && !in_operand[63] && (in_operand != 64'sd0))
            state_nxt = bkm_pkg::FS_NORM;
          else
            state_nxt = bkm_pkg::FS_PUSH;
        end
      end
      bkm_pkg::FS_NORM: begin
        if (job_r.val[62]) state_nxt = bkm_pkg::FS_PUSH;
      end
      bkm_pkg::FS_PUSH: begin
        if (!qstat.full) state_nxt = bkm_pkg::FS_IDLE;
      end
      default: state_nxt = bkm_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      bkm_pkg::FS_IDLE: in_ready = 1'b1;
      bkm_pkg::FS_NORM: ;
      bkm_pkg::FS_PUSH: push = !qstat.full;
      default: ;
    endcase
  end

  always_comb begin
    job_nxt = job_r;
    if ((state_r == bkm_pkg::FS_IDLE) && in_valid) begin
      job_nxt.p  = 6'd62;
      job_nxt.fl = in_operand[63:bkm_pkg::FRAC_BITS];
      if (in_mode) begin
        job_nxt.kind = bkm_pkg::K_EXP;
        job_nxt.val  = {1'b0, in_operand[bkm_pkg::FRAC_BITS-1:0],
                        {(63 - bkm_pkg::FRAC_BITS){1'b0}}};
      end else begin
        job_nxt.val = in_operand;
        if (in_operand[63])               job_nxt.kind = bkm_pkg::K_UNDEF;
        else if (in_operand == 64'sd0)    job_nxt.kind = bkm_pkg::K_NEGINF;
        else                              job_nxt.kind = bkm_pkg::K_LOG;
      end
    end else if ((state_r == bkm_pkg::FS_NORM) && !job_r.val[62]) begin
      // coarse byte steps first, then single bits until bit 62 is set
      if (job_r.val[62:55] == 8'd0) begin
        job_nxt.val = job_r.val << 8;
        job_nxt.p   = job_r.p - 6'd8;
      end else begin
        job_nxt.val = job_r.val << 1;
        job_nxt.p   = job_r.p - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bkm_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign push_job = job_r;

endmodule

// ===== hdl/bkm_queue.sv =====
`timescale 1ns / 1ps

module bkm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bkm_pkg::bkm_job_t   push_job,
  input  logic                pop,
  output bkm_pkg::bkm_job_t   pop_job,
  output bkm_pkg::bkm_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bkm_pkg::bkm_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  assign pop_job     = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);

endmodule

// ===== hdl/bkm_core.sv =====
`timescale 1ns / 1ps

module bkm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        iter_count,
  input  logic              job_valid,
  input  bkm_pkg::bkm_job_t job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_result,
  output logic [1:0]        out_status
);

  localparam int F = bkm_pkg::FRAC_BITS;
  localparam logic [6:0] DEPTH7 = 7'(bkm_pkg::TABLE_DEPTH);
  localparam logic signed [65:0] LBOUND = 66'sd1 <<< (63 - F);
  localparam logic signed [65:0] SH_OFS = 66'(F - 62);

  bkm_pkg::core_state_t    state_r, state_nxt;
  bkm_pkg::bkm_kind_t      kind_r;
  logic [63:0]             xx_r, yy_r, zref_r;
  logic [5:0]              p_r;
  logic signed [bkm_pkg::INT_W-1:0] fl_r;
  logic [5:0]              k_r;
  logic                    out_valid_r;
  logic [63:0]             out_result_r;
  logic [1:0]              out_status_r;

  logic [6:0]  lim;
  logic        more;
  logic        run_en, fin_en;
  logic [63:0] shx, rom_k, sum_x, sum_y;
  logic        take;

  logic [63:0]        f64;
  logic signed [8:0]  c;
  logic signed [65:0] c_ext, sh, nsh;
  logic [63:0]        res_fin;
  logic [1:0]         st_fin;

  assign lim  = ({1'b0, iter_count} < DEPTH7) ? {1'b0, iter_count} : DEPTH7;
  assign more = ({1'b0, k_r} < lim);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bkm_pkg::CS_IDLE: begin
        if (job_valid) begin
          if ((job.kind == bkm_pkg::K_LOG) || (job.kind == bkm_pkg::K_EXP))
            state_nxt = bkm_pkg::CS_RUN;
          else
            state_nxt = bkm_pkg::CS_FIN;
        end
      end
      bkm_pkg::CS_RUN: begin
        if (!more) state_nxt = bkm_pkg::CS_FIN;
      end
      bkm_pkg::CS_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = bkm_pkg::CS_IDLE;
      end
      default: state_nxt = bkm_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    run_en = 1'b0;
    fin_en = 1'b0;
    unique case (state_r)
      bkm_pkg::CS_IDLE: pop    = job_valid;
      bkm_pkg::CS_RUN:  run_en = more;
      bkm_pkg::CS_FIN:  fin_en = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // one shift-add step per cycle
  always_comb begin
    shx   = xx_r >> k_r;
    rom_k = bkm_pkg::LOG_ROM[k_r];
    sum_x = xx_r + shx;
    sum_y = yy_r + rom_k;
    take  = (kind_r == bkm_pkg::K_LOG) ? (sum_x <= zref_r) : (sum_y <= zref_r);
  end

  // result assembly
  always_comb begin
    f64   = yy_r >> (63 - F);
    c     = $signed({3'b000, p_r}) - $signed(9'(F)) + $signed({8'd0, f64[F]});
    c_ext = 66'(c);
    sh    = $signed({{(66 - bkm_pkg::INT_W){fl_r[bkm_pkg::INT_W-1]}}, fl_r}) + SH_OFS;
    nsh   = -sh;
    res_fin = '0;
    st_fin  = bkm_pkg::ST_OK;
    case (kind_r)
      bkm_pkg::K_UNDEF: begin
        res_fin = '0;
        st_fin  = bkm_pkg::ST_UNDEF;
      end
      bkm_pkg::K_NEGINF: begin
        res_fin = bkm_pkg::ONE_Q63;
        st_fin  = bkm_pkg::ST_NEGINF;
      end
      bkm_pkg::K_LOG: begin
        if (c_ext < -LBOUND) begin
          res_fin = bkm_pkg::ONE_Q63;
          st_fin  = bkm_pkg::ST_OVF;
        end else if (c_ext >= LBOUND) begin
          res_fin = bkm_pkg::ONE_Q63 - 64'd1;
          st_fin  = bkm_pkg::ST_OVF;
        end else begin
          res_fin = (c_ext[63:0] << F) | {{(64 - F){1'b0}}, f64[F-1:0]};
        end
      end
      default: begin
        if ((sh > 66'sd0) || ((sh == 66'sd0) && xx_r[63])) begin
          res_fin = bkm_pkg::ONE_Q63 - 64'd1;
          st_fin  = bkm_pkg::ST_OVF;
        end else if (sh == 66'sd0) begin
          res_fin = xx_r;
        end else if (sh <= -66'sd64) begin
          res_fin = '0;
        end else begin
          res_fin = xx_r >> nsh[5:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bkm_pkg::CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_en)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= job.kind;
      zref_r <= job.val;
      p_r    <= job.p;
      fl_r   <= job.fl;
      xx_r   <= bkm_pkg::ONE_Q62;
      yy_r   <= '0;
      k_r    <= (job.kind == bkm_pkg::K_LOG) ? 6'd1 : 6'd0;
    end else if (run_en) begin
      if (take) begin
        xx_r <= sum_x;
        yy_r <= sum_y;
      end
      k_r <= k_r + 6'd1;
    end
    if (fin_en) begin
      out_result_r <= res_fin;
      out_status_r <= st_fin;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule
